// ===== design/srt_pkg.sv =====
// Shared types and codes for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps

package srt_pkg;

   // Item kinds carried on the request channel.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Controller states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_FETCH  = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // append the request beat to the table
      logic start;    // open a tick: clear the scan and the pick
      logic scan;     // walk the table one entry per cycle
      logic fetch;    // read the chosen entry's burst
      logic update;   // run the chosen entry for one unit
      logic publish;  // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end; // every loaded entry has been issued
   } status_type;

endpackage

// ===== design/srt_if.sv =====
// Handshake channels of the scheduler: request beats and result beats.
`timescale 1ns / 1ps

interface srt_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] arrive_tick;
   logic [15:0] burst_len;

   modport source (output valid, kind, arrive_tick, burst_len, input ready);
   modport sink   (input valid, kind, arrive_tick, burst_len, output ready);
endinterface

interface srt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] tick_time;
   logic        cpu_idle;
   logic [3:0]  runner_index;
   logic        segment_start;
   logic        first_dispatch;
   logic [15:0] response_delay;
   logic        finished;
   logic [15:0] turnaround;
   logic [15:0] wait_total;
   logic        all_done;

   modport source (output valid, tick_time, cpu_idle, runner_index, segment_start,
                   first_dispatch, response_delay, finished, turnaround, wait_total,
                   all_done, input ready);
   modport sink   (input valid, tick_time, cpu_idle, runner_index, segment_start,
                   first_dispatch, response_delay, finished, turnaround, wait_total,
                   all_done, output ready);
endinterface

// ===== design/srt_ctrl.sv =====
// Controller state machine of the scheduler: sequences loads and ticks.
`timescale 1ns / 1ps

module srt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  srt_pkg::status_type status,
   output srt_pkg::cmd_type    cmd
);

   srt_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   logic               accept;

   // A request beat is taken only between ticks.
   assign req_ready = (state_ff == srt_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         srt_pkg::ST_IDLE: begin
            if (accept && (req_kind == srt_pkg::KIND_TICK)) begin
               cmd.start = 1'b1;
               state_in  = srt_pkg::ST_SCAN;
            end else if (accept) begin
               cmd.load = 1'b1;
            end
         end
         srt_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_end) begin
               state_in = srt_pkg::ST_DRAIN;
            end
         end
         srt_pkg::ST_DRAIN: begin
            state_in = srt_pkg::ST_FETCH;
         end
         srt_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = srt_pkg::ST_UPDATE;
         end
         srt_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = srt_pkg::ST_FINISH;
         end
         srt_pkg::ST_FINISH: begin
            // Wait here until the result register is free.
            if (!out_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = srt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srt_pkg::ST_IDLE;
         end
      endcase
   end

   // The result beat stays valid until the receiver takes it.
   always_comb begin
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srt_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== design/srt_dp.sv =====
// Datapath of the scheduler: process table, minimum scan, timing arithmetic.
`timescale 1ns / 1ps

module srt_dp #(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  srt_pkg::cmd_type    cmd,
   output srt_pkg::status_type status,
   input  logic [15:0]         arrive_tick,
   input  logic [15:0]         burst_len,
   output logic [15:0]         tick_time,
   output logic                cpu_idle,
   output logic [3:0]          runner_index,
   output logic                segment_start,
   output logic                first_dispatch,
   output logic [15:0]         response_delay,
   output logic                finished,
   output logic [15:0]         turnaround,
   output logic [15:0]         wait_total,
   output logic                all_done
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam int RX_W  = (IDX_W > 4) ? IDX_W : 4;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   // Process table memories.
   logic [TIME_BITS-1:0] arr_mem [MAX_PROCS];
   logic [15:0]          bur_mem [MAX_PROCS];
   logic [15:0]          rem_mem [MAX_PROCS];
   logic [MAX_PROCS-1:0] started_ff;
   logic [MAX_PROCS-1:0] done_ff;

   logic [CNT_W-1:0]     loaded_ff, fin_ff, scan_idx_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 last_valid_ff, last_idle_ff;
   logic [IDX_W-1:0]     last_idx_ff;

   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [TIME_BITS-1:0] arr_q;
   logic [15:0]          bur_q, rem_q;

   logic                 pick_valid_ff;
   logic [IDX_W-1:0]     pick_idx_ff;
   logic [15:0]          best_ff;
   logic [TIME_BITS-1:0] pick_arr_ff;

   logic                 res_idle_ff, res_seg_ff, res_first_ff, res_fin_ff;
   logic [TIME_BITS-1:0] res_tick_ff, res_resp_ff, res_turn_ff;

   logic                 room, issue, rd_en, elig, better, fin_now;
   logic [IDX_W-1:0]     rd_addr, rem_waddr;
   logic                 rem_we;
   logic [15:0]          rem_wdata;
   logic [CMP_W-1:0]     arr_in_ext;
   logic [TIME_BITS-1:0] now_next;
   logic [CMP_W-1:0]     turn_ext, bur_ext, wait_ext, tick_ext, resp_ext;
   logic [RX_W-1:0]      runner_ext;

   assign room            = loaded_ff < CNT_W'(MAX_PROCS);
   assign status.scan_end = (scan_idx_ff == loaded_ff);
   assign issue           = cmd.scan && !status.scan_end;
   assign rd_en           = issue || cmd.fetch;
   assign rd_addr         = cmd.fetch ? pick_idx_ff : scan_idx_ff[IDX_W-1:0];
   assign arr_in_ext      = CMP_W'(arrive_tick);

   // Remaining-time write port: a load fills it, a run counts it down.
   assign fin_now = (best_ff <= 16'd1);
   always_comb begin
      rem_we    = 1'b0;
      rem_waddr = loaded_ff[IDX_W-1:0];
      rem_wdata = burst_len;
      if (cmd.load && room) begin
         rem_we = 1'b1;
      end else if (cmd.update && pick_valid_ff) begin
         rem_we    = 1'b1;
         rem_waddr = pick_idx_ff;
         rem_wdata = fin_now ? 16'd0 : (best_ff - 16'd1);
      end
   end

   // Table memories, one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         arr_mem[loaded_ff[IDX_W-1:0]] <= arr_in_ext[TIME_BITS-1:0];
         bur_mem[loaded_ff[IDX_W-1:0]] <= burst_len;
      end
      if (rem_we) begin
         rem_mem[rem_waddr] <= rem_wdata;
      end
      if (rd_en) begin
         arr_q <= arr_mem[rd_addr];
         bur_q <= bur_mem[rd_addr];
         rem_q <= rem_mem[rd_addr];
      end
   end

   // Per-entry flags: cleared on load, set when an entry runs or completes.
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         started_ff[loaded_ff[IDX_W-1:0]] <= 1'b0;
         done_ff[loaded_ff[IDX_W-1:0]]    <= 1'b0;
      end else if (cmd.update && pick_valid_ff) begin
         started_ff[pick_idx_ff] <= 1'b1;
         if (fin_now) begin
            done_ff[pick_idx_ff] <= 1'b1;
         end
      end
   end

   // Scan pointer and the read-valid pipe that follows the memory latency.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            scan_idx_ff <= '0;
         end else if (issue) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         rd_valid_ff <= issue;
      end
      rd_idx_ff <= scan_idx_ff[IDX_W-1:0];
   end

   // Running minimum: strict less-than keeps the lowest index on ties.
   assign elig   = rd_valid_ff && !done_ff[rd_idx_ff] && (arr_q <= now_ff);
   assign better = elig && (!pick_valid_ff || (rem_q < best_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_valid_ff <= 1'b0;
      end else if (cmd.start) begin
         pick_valid_ff <= 1'b0;
      end else if (better) begin
         pick_valid_ff <= 1'b1;
      end
      if (better) begin
         pick_idx_ff <= rd_idx_ff;
         best_ff     <= rem_q;
         pick_arr_ff <= arr_q;
      end
   end

   // Saturating clock of the schedule.
   assign now_next = (now_ff == TIME_MAX) ? now_ff : (now_ff + 1'b1);

   // Counters, timeline history and the run of one unit.
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= '0;
         fin_ff        <= '0;
         now_ff        <= '0;
         last_valid_ff <= 1'b0;
         last_idle_ff  <= 1'b0;
         last_idx_ff   <= '0;
      end else begin
         if (cmd.load && room) begin
            loaded_ff <= loaded_ff + 1'b1;
         end
         if (cmd.update) begin
            now_ff <= now_next;
            if (pick_valid_ff) begin
               last_valid_ff <= 1'b1;
               last_idx_ff   <= pick_idx_ff;
               last_idle_ff  <= 1'b0;
               if (fin_now) begin
                  fin_ff <= fin_ff + 1'b1;
               end
            end else begin
               last_valid_ff <= 1'b0;
               last_idle_ff  <= 1'b1;
            end
         end
      end
   end

   // Tick results held for the final stage.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_tick_ff  <= now_ff;
         res_idle_ff  <= !pick_valid_ff;
         res_resp_ff  <= now_ff - pick_arr_ff;
         res_turn_ff  <= now_next - pick_arr_ff;
         if (pick_valid_ff) begin
            res_seg_ff   <= !last_valid_ff || (last_idx_ff != pick_idx_ff);
            res_first_ff <= !started_ff[pick_idx_ff];
            res_fin_ff   <= fin_now;
         end else begin
            res_seg_ff   <= !last_idle_ff;
            res_first_ff <= 1'b0;
            res_fin_ff   <= 1'b0;
         end
      end
   end

   // Waiting time, clamped at zero when saturation shortened the turnaround.
   assign turn_ext   = CMP_W'(res_turn_ff);
   assign bur_ext    = CMP_W'(bur_q);
   assign wait_ext   = (turn_ext >= bur_ext) ? (turn_ext - bur_ext) : '0;
   assign tick_ext   = CMP_W'(res_tick_ff);
   assign resp_ext   = CMP_W'(res_resp_ff);
   assign runner_ext = RX_W'(pick_idx_ff);

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         tick_time      <= tick_ext[15:0];
         cpu_idle       <= res_idle_ff;
         runner_index   <= res_idle_ff ? 4'd0 : runner_ext[3:0];
         segment_start  <= res_seg_ff;
         first_dispatch <= res_first_ff;
         response_delay <= res_first_ff ? resp_ext[15:0] : 16'd0;
         finished       <= res_fin_ff;
         turnaround     <= res_fin_ff ? turn_ext[15:0] : 16'd0;
         wait_total     <= res_fin_ff ? wait_ext[15:0] : 16'd0;
         all_done       <= (fin_ff == loaded_ff);
      end
   end

`ifndef ASSERT_OFF
   a_fin_le_loaded: assert property (@(posedge clock) disable iff (reset)
      fin_ff <= loaded_ff)
      else $error("more completions than loaded processes");

   a_pick_loaded: assert property (@(posedge clock) disable iff (reset)
      (cmd.fetch && pick_valid_ff) |-> (CNT_W'(pick_idx_ff) < loaded_ff))
      else $error("chosen entry lies beyond the loaded table");

   a_fin_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && pick_valid_ff && fin_now) |=> (fin_ff == $past(fin_ff) + 1'b1))
      else $error("completion not counted");
`endif

endmodule

// ===== design/srt_preemptive_scheduler.sv =====
// Top level of the preemptive shortest-remaining-time scheduler.
//
// Usage: beats arrive on req_chan with kind, arrive_tick and burst_len.
// A load beat (kind 0) appends one process to a table of MAX_PROCS entries in
// the cycle it is taken and gives no result; loads into a full table are dropped.
// A tick beat (kind 1) chooses the arrived, unfinished entry with the least
// remaining time, runs it for one unit and yields one result beat on rsp_chan.
// A tick: the controller walks the table one entry per cycle through a single
// registered memory read port, detects the end of the table, then steps
// through pipeline drain, fetching the burst, the update and the result stage.
// One tick is processed at a time; a new request is taken once the previous
// tick has moved into the result register.
// Reset clears the table, the time counter and the segment history.
// If the receiver stalls, the result beat holds on rsp_chan; loads are still
// taken, and the next tick stops in its last stage until the beat is taken.
`timescale 1ns / 1ps

module srt_preemptive_scheduler #(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   srt_req_if.sink   req_chan,
   srt_rsp_if.source rsp_chan
);

   srt_pkg::cmd_type    cmd;
   srt_pkg::status_type status;

   // Sequencing.
   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, scan and arithmetic.
   srt_dp #(
      .MAX_PROCS (MAX_PROCS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .arrive_tick    (req_chan.arrive_tick),
      .burst_len      (req_chan.burst_len),
      .tick_time      (rsp_chan.tick_time),
      .cpu_idle       (rsp_chan.cpu_idle),
      .runner_index   (rsp_chan.runner_index),
      .segment_start  (rsp_chan.segment_start),
      .first_dispatch (rsp_chan.first_dispatch),
      .response_delay (rsp_chan.response_delay),
      .finished       (rsp_chan.finished),
      .turnaround     (rsp_chan.turnaround),
      .wait_total     (rsp_chan.wait_total),
      .all_done       (rsp_chan.all_done)
   );

endmodule
